/* hw/rtl/aldp_pkg.sv */
// Shared types, constants and tables of the arc and line path densifier.
// Used by the top level, the CORDIC unit and the square root unit.
package aldp_pkg;

    localparam int IN_W  = 208;
    localparam int OUT_W = 120;

    localparam logic signed [22:0] PI_Q16      = 23'sd205887;
    localparam logic signed [22:0] HALF_PI_Q16 = 23'sd102944;
    localparam logic signed [22:0] TWO_PI_Q16  = 23'sd411775;
    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
    localparam logic [4:0] CORDIC_LAST = 5'd23;

    localparam logic [16:0] STEP_RESET = 17'd3432;
    localparam logic [15:0] DUP_RESET  = 16'd43;

    localparam logic CFG_STEP = 1'b0;
    localparam logic CFG_DUP  = 1'b1;

    typedef enum logic [1:0] {CO_IDLE, CO_WRAP, CO_ROT} cordic_state_t;
    typedef enum logic [1:0] {SQ_IDLE, SQ_MUL, SQ_ROOT} sqrt_state_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ADD, ST_SQRT, ST_EMIT, ST_NEXT, ST_END, ST_FLUSH,
        ST_ARC_SETUP, ST_DIV_A, ST_DIV_B, ST_ANGLE, ST_CORDIC, ST_MUL,
        ST_ROUND, ST_CAND
    } state_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic               smooth;
        logic [39:0]        distance;
        logic [9:0]         point_index;
        logic               path_end;
    } result_t;

    function automatic logic [23:0] atan_q24(input logic [4:0] i);
        logic [23:0] v;
        unique case (i)
            5'd0:  v = 24'd13176795;
            5'd1:  v = 24'd7778716;
            5'd2:  v = 24'd4110060;
            5'd3:  v = 24'd2086331;
            5'd4:  v = 24'd1047214;
            5'd5:  v = 24'd524117;
            5'd6:  v = 24'd262123;
            5'd7:  v = 24'd131069;
            5'd8:  v = 24'd65536;
            5'd9:  v = 24'd32768;
            5'd10: v = 24'd16384;
            5'd11: v = 24'd8192;
            5'd12: v = 24'd4096;
            5'd13: v = 24'd2048;
            5'd14: v = 24'd1024;
            5'd15: v = 24'd512;
            5'd16: v = 24'd256;
            5'd17: v = 24'd128;
            5'd18: v = 24'd64;
            5'd19: v = 24'd32;
            5'd20: v = 24'd16;
            5'd21: v = 24'd8;
            5'd22: v = 24'd4;
            5'd23: v = 24'd2;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/arc_line_path_densifier_unit.sv */
// Arc and line path densifier: segment sequencer, serial dividers and multiplier.
// Depends on aldp_pkg, aldp_cordic and aldp_sqrt.
// One segment at a time. Line: 2 points. Arc: setup, then for each of steps+1 samples
// the CORDIC unit, the serial multiply and the length unit; stalls on m_tready
// can hold the sequence.
// Reset (aresetn low, synchronous) empties the path and restores register defaults.
module arc_line_path_densifier_unit #(
    parameter int MAX_POINTS    = 1024,
    parameter int MAX_ARC_STEPS = 60
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // first_x, first_y, second_x, second_y, radius, start_angle, end_angle
    input  logic [aldp_pkg::IN_W-1:0]  s_tdata,
    // kind, path_start
    input  logic [1:0]                 s_tuser,
    input  logic                       s_tlast,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // point_x, point_y, distance, point_index
    output logic [aldp_pkg::OUT_W-1:0] m_tdata,
    // smooth, path_end
    output logic [1:0]                 m_tuser,
    output logic                       m_tlast,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_addr,
    input  logic [16:0]                cfg_wdata
);
    import aldp_pkg::*;

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int STEP_W = $clog2(MAX_ARC_STEPS + 1);

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        if (v[34:31] != {4{v[34]}})
            return v[34] ? 32'sh80000000 : 32'sh7fffffff;
        return v[31:0];
    endfunction

    state_t state_reg, state_next;
    logic [16:0] step_reg;
    logic [15:0] dup_reg;

    logic               kind_reg, kind_next, last_reg, last_next;
    logic signed [31:0] fx_reg, fx_next, fy_reg, fy_next;
    logic signed [31:0] sx_reg, sx_next, sy_reg, sy_next;
    logic [30:0]        rad_reg, rad_next;
    logic signed [20:0] sa_reg, sa_next, ea_reg, ea_next;
    logic               line_ph_reg, line_ph_next;

    logic               held_v_reg, held_v_next;
    logic signed [31:0] held_x_reg, held_x_next, held_y_reg, held_y_next;
    logic               held_sm_reg, held_sm_next;
    logic [39:0]        held_d_reg, held_d_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic signed [31:0] cand_x_reg, cand_x_next, cand_y_reg, cand_y_next;
    logic               cand_sm_reg, cand_sm_next;
    logic [39:0]        nd_reg, nd_next;

    logic [20:0] div_q_reg, div_q_next;
    logic [17:0] div_r_reg, div_r_next;
    logic [16:0] div_d_reg, div_d_next;
    logic [4:0]  div_cnt_reg, div_cnt_next;
    logic        neg_reg, neg_next;
    logic [20:0] mag_reg, mag_next;
    logic [STEP_W-1:0] steps_reg, steps_next, rb_reg, rb_next, j_reg, j_next;
    logic [STEP_W-1:0] rj_reg, rj_next;
    logic [20:0] qb_reg, qb_next, qj_reg, qj_next;

    logic signed [63:0] mcx_reg, mcx_next, mcy_reg, mcy_next;
    logic signed [63:0] accx_reg, accx_next, accy_reg, accy_next;
    logic [30:0]        mr_reg, mr_next;
    logic [4:0]         mul_cnt_reg, mul_cnt_next;
    logic signed [33:0] ox_reg, ox_next, oy_reg, oy_next;

    result_t pend_reg, pend_next, out_reg, out_next;
    logic    pend_v_reg, pend_v_next, out_v_reg, out_v_next, out_l_reg, out_l_next;

    logic [17:0]        rem_sh, r_new;
    logic [20:0]        q_new;
    logic               ge;
    logic signed [21:0] sweep;
    logic signed [22:0] ang;
    logic               co_start, co_done;
    logic signed [31:0] co_cos, co_sin;
    logic signed [32:0] dx, dy;
    logic [32:0]        ux, uy;
    logic [16:0]        sq_small;
    logic               dup;
    logic               sq_start, sq_done;
    logic [33:0]        sq_root;
    logic [40:0]        dsum;
    logic [STEP_W:0]    rsum;
    logic signed [63:0] rx, ry;
    logic signed [34:0] sum_x, sum_y;
    logic [CNT_W-1:0]   idx_w;
    logic               push_ok, push;
    result_t            push_res;

    aldp_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (co_start),
        .angle   (ang),
        .done    (co_done),
        .cos_q30 (co_cos),
        .sin_q30 (co_sin)
    );

    aldp_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .ux      (ux),
        .uy      (uy),
        .done    (sq_done),
        .root    (sq_root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_RESET;
            dup_reg  <= DUP_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_STEP: step_reg <= cfg_wdata;
                CFG_DUP:  dup_reg  <= cfg_wdata[15:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            held_v_reg <= 1'b0;
            cnt_reg    <= '0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            held_v_reg <= held_v_next;
            cnt_reg    <= cnt_next;
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        last_reg    <= last_next;
        fx_reg      <= fx_next;
        fy_reg      <= fy_next;
        sx_reg      <= sx_next;
        sy_reg      <= sy_next;
        rad_reg     <= rad_next;
        sa_reg      <= sa_next;
        ea_reg      <= ea_next;
        line_ph_reg <= line_ph_next;
        held_x_reg  <= held_x_next;
        held_y_reg  <= held_y_next;
        held_sm_reg <= held_sm_next;
        held_d_reg  <= held_d_next;
        cand_x_reg  <= cand_x_next;
        cand_y_reg  <= cand_y_next;
        cand_sm_reg <= cand_sm_next;
        nd_reg      <= nd_next;
        div_q_reg   <= div_q_next;
        div_r_reg   <= div_r_next;
        div_d_reg   <= div_d_next;
        div_cnt_reg <= div_cnt_next;
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        steps_reg   <= steps_next;
        rb_reg      <= rb_next;
        qb_reg      <= qb_next;
        j_reg       <= j_next;
        rj_reg      <= rj_next;
        qj_reg      <= qj_next;
        mcx_reg     <= mcx_next;
        mcy_reg     <= mcy_next;
        accx_reg    <= accx_next;
        accy_reg    <= accy_next;
        mr_reg      <= mr_next;
        mul_cnt_reg <= mul_cnt_next;
        ox_reg      <= ox_next;
        oy_reg      <= oy_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
        out_l_reg   <= out_l_next;
    end

    // shared datapath terms
    always_comb begin
        rem_sh = {div_r_reg[16:0], div_q_reg[20]};
        ge     = (rem_sh >= {1'b0, div_d_reg});
        r_new  = ge ? rem_sh - {1'b0, div_d_reg} : rem_sh;
        q_new  = {div_q_reg[19:0], ge};
        sweep  = 22'(ea_reg) - 22'(sa_reg);
        ang    = 23'(sa_reg) + (neg_reg ? -$signed({2'b00, qj_reg})
                                        : $signed({2'b00, qj_reg}));
        dx     = 33'(cand_x_reg) - 33'(held_x_reg);
        dy     = 33'(cand_y_reg) - 33'(held_y_reg);
        ux     = dx[32] ? 33'(-dx) : 33'(dx);
        uy     = dy[32] ? 33'(-dy) : 33'(dy);
        sq_small = 17'(ux[7:0] * ux[7:0]) + 17'(uy[7:0] * uy[7:0]);
        dup    = (ux < 33'd256) && (uy < 33'd256) && (sq_small < {1'b0, dup_reg});
        dsum   = {1'b0, held_d_reg} + 41'(sq_root);
        rsum   = {1'b0, rj_reg} + {1'b0, rb_reg};
        rx     = accx_reg + 64'sd536870912;
        ry     = accy_reg + 64'sd536870912;
        sum_x  = 35'(fx_reg) + 35'(ox_reg);
        sum_y  = 35'(fy_reg) + 35'(oy_reg);
        idx_w  = cnt_reg - CNT_W'(1);
        push_ok = !pend_v_reg || !out_v_reg || m_tready;
        push_res.point_x     = held_x_reg;
        push_res.point_y     = held_y_reg;
        push_res.smooth      = held_sm_reg;
        push_res.distance    = held_d_reg;
        push_res.point_index = 10'(idx_w);
        push_res.path_end    = 1'b0;
    end

    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        last_next    = last_reg;
        fx_next      = fx_reg;
        fy_next      = fy_reg;
        sx_next      = sx_reg;
        sy_next      = sy_reg;
        rad_next     = rad_reg;
        sa_next      = sa_reg;
        ea_next      = ea_reg;
        line_ph_next = line_ph_reg;
        held_v_next  = held_v_reg;
        held_x_next  = held_x_reg;
        held_y_next  = held_y_reg;
        held_sm_next = held_sm_reg;
        held_d_next  = held_d_reg;
        cnt_next     = cnt_reg;
        cand_x_next  = cand_x_reg;
        cand_y_next  = cand_y_reg;
        cand_sm_next = cand_sm_reg;
        nd_next      = nd_reg;
        div_q_next   = div_q_reg;
        div_r_next   = div_r_reg;
        div_d_next   = div_d_reg;
        div_cnt_next = div_cnt_reg;
        neg_next     = neg_reg;
        mag_next     = mag_reg;
        steps_next   = steps_reg;
        rb_next      = rb_reg;
        qb_next      = qb_reg;
        j_next       = j_reg;
        rj_next      = rj_reg;
        qj_next      = qj_reg;
        mcx_next     = mcx_reg;
        mcy_next     = mcy_reg;
        accx_next    = accx_reg;
        accy_next    = accy_reg;
        mr_next      = mr_reg;
        mul_cnt_next = mul_cnt_reg;
        ox_next      = ox_reg;
        oy_next      = oy_reg;
        co_start     = 1'b0;
        sq_start     = 1'b0;
        push         = 1'b0;
        pend_next    = pend_reg;
        pend_v_next  = pend_v_reg;
        out_next     = out_reg;
        out_l_next   = out_l_reg;
        out_v_next   = out_v_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next    = s_tuser[0];
                    last_next    = s_tlast;
                    fx_next      = s_tdata[31:0];
                    fy_next      = s_tdata[63:32];
                    sx_next      = s_tdata[95:64];
                    sy_next      = s_tdata[127:96];
                    rad_next     = s_tdata[158:128];
                    sa_next      = s_tdata[179:159];
                    ea_next      = s_tdata[200:180];
                    if (s_tuser[1]) begin
                        held_v_next = 1'b0;
                        cnt_next    = '0;
                    end
                    if (!s_tuser[0]) begin
                        cand_x_next  = s_tdata[31:0];
                        cand_y_next  = s_tdata[63:32];
                        cand_sm_next = 1'b0;
                        line_ph_next = 1'b0;
                        state_next   = ST_ADD;
                    end else begin
                        state_next = ST_ARC_SETUP;
                    end
                end
            end
            ST_ARC_SETUP: begin
                neg_next     = sweep[21];
                mag_next     = sweep[21] ? 21'(-sweep) : sweep[20:0];
                div_q_next   = mag_next;
                div_r_next   = '0;
                div_d_next   = (step_reg == '0) ? 17'd1 : step_reg;
                div_cnt_next = '0;
                state_next   = ST_DIV_A;
            end
            ST_DIV_A: begin
                div_q_next   = q_new;
                div_r_next   = r_new;
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'd20) begin
                    priority if (q_new >= 21'(MAX_ARC_STEPS - 1))
                        steps_next = STEP_W'(MAX_ARC_STEPS);
                    else if (q_new == '0)
                        steps_next = STEP_W'(2);
                    else
                        steps_next = STEP_W'(q_new + 21'd1);
                    div_q_next   = mag_reg;
                    div_r_next   = '0;
                    div_d_next   = 17'(steps_next);
                    div_cnt_next = '0;
                    state_next   = ST_DIV_B;
                end
            end
            ST_DIV_B: begin
                div_q_next   = q_new;
                div_r_next   = r_new;
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'd20) begin
                    qb_next    = q_new;
                    rb_next    = r_new[STEP_W-1:0];
                    j_next     = '0;
                    qj_next    = '0;
                    rj_next    = '0;
                    state_next = ST_ANGLE;
                end
            end
            ST_ANGLE: begin
                co_start   = 1'b1;
                state_next = ST_CORDIC;
            end
            ST_CORDIC: begin
                if (co_done) begin
                    mcx_next     = 64'(co_cos);
                    mcy_next     = 64'(co_sin);
                    accx_next    = '0;
                    accy_next    = '0;
                    mr_next      = rad_reg;
                    mul_cnt_next = '0;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL: begin
                accx_next    = accx_reg + (mr_reg[0] ? mcx_reg : 64'sd0);
                accy_next    = accy_reg + (mr_reg[0] ? mcy_reg : 64'sd0);
                mcx_next     = mcx_reg <<< 1;
                mcy_next     = mcy_reg <<< 1;
                mr_next      = {1'b0, mr_reg[30:1]};
                mul_cnt_next = mul_cnt_reg + 5'd1;
                if (mul_cnt_reg == 5'd30)
                    state_next = ST_ROUND;
            end
            ST_ROUND: begin
                ox_next    = rx[63:30];
                oy_next    = ry[63:30];
                state_next = ST_CAND;
            end
            ST_CAND: begin
                cand_x_next  = sat32(sum_x);
                cand_y_next  = sat32(sum_y);
                cand_sm_next = (j_reg != '0) && (j_reg != steps_reg);
                state_next   = ST_ADD;
            end
            ST_ADD: begin
                priority if (cnt_reg >= CNT_W'(MAX_POINTS)) begin
                    state_next = ST_NEXT;
                end else if (!held_v_reg) begin
                    held_x_next  = cand_x_reg;
                    held_y_next  = cand_y_reg;
                    held_sm_next = cand_sm_reg;
                    held_d_next  = '0;
                    held_v_next  = 1'b1;
                    cnt_next     = cnt_reg + CNT_W'(1);
                    state_next   = ST_NEXT;
                end else if (dup) begin
                    held_sm_next = held_sm_reg | cand_sm_reg;
                    state_next   = ST_NEXT;
                end else begin
                    sq_start   = 1'b1;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (sq_done) begin
                    nd_next    = dsum[40] ? '1 : dsum[39:0];
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (push_ok) begin
                    push         = 1'b1;
                    held_x_next  = cand_x_reg;
                    held_y_next  = cand_y_reg;
                    held_sm_next = cand_sm_reg;
                    held_d_next  = nd_reg;
                    cnt_next     = cnt_reg + CNT_W'(1);
                    state_next   = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (!kind_reg) begin
                    if (!line_ph_reg) begin
                        line_ph_next = 1'b1;
                        cand_x_next  = sx_reg;
                        cand_y_next  = sy_reg;
                        cand_sm_next = 1'b0;
                        state_next   = ST_ADD;
                    end else begin
                        state_next = ST_END;
                    end
                end else if (j_reg == steps_reg) begin
                    state_next = ST_END;
                end else begin
                    j_next = j_reg + STEP_W'(1);
                    if (rsum >= {1'b0, steps_reg}) begin
                        rj_next = STEP_W'(rsum - {1'b0, steps_reg});
                        qj_next = qj_reg + qb_reg + 21'd1;
                    end else begin
                        rj_next = rsum[STEP_W-1:0];
                        qj_next = qj_reg + qb_reg;
                    end
                    state_next = ST_ANGLE;
                end
            end
            ST_END: begin
                if (!last_reg) begin
                    state_next = ST_FLUSH;
                end else if (!held_v_reg) begin
                    cnt_next   = '0;
                    state_next = ST_FLUSH;
                end else if (push_ok) begin
                    push        = 1'b1;
                    held_v_next = 1'b0;
                    cnt_next    = '0;
                    state_next  = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!pend_v_reg) begin
                    state_next = ST_IDLE;
                end else if (!out_v_reg || m_tready) begin
                    out_next    = pend_reg;
                    out_l_next  = 1'b1;
                    out_v_next  = 1'b1;
                    pend_v_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // a new result parks in the pending slot; the previous one moves out
        if (push) begin
            if (pend_v_reg) begin
                out_next   = pend_reg;
                out_l_next = 1'b0;
                out_v_next = 1'b1;
            end
            pend_next          = push_res;
            pend_next.path_end = (state_reg == ST_END);
            pend_v_next        = 1'b1;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_v_reg;
    assign m_tlast  = out_l_reg;
    assign m_tuser  = {out_reg.path_end, out_reg.smooth};
    assign m_tdata  = {6'b0, out_reg.point_index, out_reg.distance,
                       out_reg.point_y, out_reg.point_x};

endmodule

/* hw/rtl/aldp_cordic.sv */
// Iterative rotation CORDIC: angle wrap, quadrant fold, 24 rotations.
// Depends on aldp_pkg (constants, arctangent table, state type).
module aldp_cordic (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [22:0] angle,
    output logic               done,
    output logic signed [31:0] cos_q30,
    output logic signed [31:0] sin_q30
);
    import aldp_pkg::*;

    cordic_state_t      state_reg, state_next;
    logic               done_reg, done_next;
    logic signed [22:0] a_reg, a_next;
    logic               neg_reg, neg_next;
    logic signed [31:0] x_reg, x_next, y_reg, y_next;
    logic signed [27:0] z_reg, z_next;
    logic [4:0]         i_reg, i_next;
    logic signed [31:0] cos_reg, cos_next, sin_reg, sin_next;
    logic signed [31:0] xs, ys;
    logic signed [27:0] at;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CO_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        neg_reg <= neg_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        i_reg   <= i_next;
        cos_reg <= cos_next;
        sin_reg <= sin_next;
    end

    always_comb begin
        state_next = state_reg;
        done_next  = 1'b0;
        a_next     = a_reg;
        neg_next   = neg_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        i_next     = i_reg;
        cos_next   = cos_reg;
        sin_next   = sin_reg;
        xs         = x_reg >>> i_reg;
        ys         = y_reg >>> i_reg;
        at         = $signed({4'b0000, atan_q24(i_reg)});
        unique case (state_reg)
            CO_IDLE: begin
                if (start) begin
                    a_next     = angle;
                    state_next = CO_WRAP;
                end
            end
            CO_WRAP: begin
                priority if (a_reg > PI_Q16) begin
                    a_next = a_reg - TWO_PI_Q16;
                end else if (a_reg < -PI_Q16) begin
                    a_next = a_reg + TWO_PI_Q16;
                end else begin
                    priority if (a_reg > HALF_PI_Q16) begin
                        a_next   = a_reg - PI_Q16;
                        neg_next = 1'b1;
                    end else if (a_reg < -HALF_PI_Q16) begin
                        a_next   = a_reg + PI_Q16;
                        neg_next = 1'b1;
                    end else begin
                        a_next   = a_reg;
                        neg_next = 1'b0;
                    end
                    z_next     = {a_next[19:0], 8'b0};
                    x_next     = CORDIC_GAIN_Q30;
                    y_next     = '0;
                    i_next     = '0;
                    state_next = CO_ROT;
                end
            end
            CO_ROT: begin
                if (!z_reg[27]) begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - at;
                end else begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + at;
                end
                i_next = i_reg + 5'd1;
                if (i_reg == CORDIC_LAST) begin
                    cos_next   = neg_reg ? -x_next : x_next;
                    sin_next   = neg_reg ? -y_next : y_next;
                    done_next  = 1'b1;
                    state_next = CO_IDLE;
                end
            end
            default: state_next = CO_IDLE;
        endcase
    end

    assign done    = done_reg;
    assign cos_q30 = cos_reg;
    assign sin_q30 = sin_reg;

endmodule

/* hw/rtl/aldp_sqrt.sv */
// Segment length: serial shift-add squares, then restoring square root,
// one bit per cycle. Depends on aldp_pkg (state type).
module aldp_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [32:0] ux,
    input  logic [32:0] uy,
    output logic        done,
    output logic [33:0] root
);
    import aldp_pkg::*;

    sqrt_state_t state_reg, state_next;
    logic        done_reg, done_next;
    logic [65:0] mx_reg, mx_next, my_reg, my_next;
    logic [32:0] bx_reg, bx_next, by_reg, by_next;
    logic [66:0] acc_reg, acc_next;
    logic [67:0] rad_reg, rad_next;
    logic [35:0] rem_reg, rem_next;
    logic [33:0] rt_reg, rt_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [35:0] rem_sh, trial;
    logic        ge;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SQ_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        mx_reg  <= mx_next;
        my_reg  <= my_next;
        bx_reg  <= bx_next;
        by_reg  <= by_next;
        acc_reg <= acc_next;
        rad_reg <= rad_next;
        rem_reg <= rem_next;
        rt_reg  <= rt_next;
        cnt_reg <= cnt_next;
    end

    always_comb begin
        state_next = state_reg;
        done_next  = 1'b0;
        mx_next    = mx_reg;
        my_next    = my_reg;
        bx_next    = bx_reg;
        by_next    = by_reg;
        acc_next   = acc_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        rt_next    = rt_reg;
        cnt_next   = cnt_reg;
        rem_sh     = {rem_reg[33:0], rad_reg[67:66]};
        trial      = {rt_reg, 2'b01};
        ge         = (rem_sh >= trial);
        unique case (state_reg)
            SQ_IDLE: begin
                if (start) begin
                    mx_next    = {33'b0, ux};
                    my_next    = {33'b0, uy};
                    bx_next    = ux;
                    by_next    = uy;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = SQ_MUL;
                end
            end
            SQ_MUL: begin
                acc_next = acc_reg + (bx_reg[0] ? {1'b0, mx_reg} : 67'd0)
                                   + (by_reg[0] ? {1'b0, my_reg} : 67'd0);
                mx_next  = {mx_reg[64:0], 1'b0};
                my_next  = {my_reg[64:0], 1'b0};
                bx_next  = {1'b0, bx_reg[32:1]};
                by_next  = {1'b0, by_reg[32:1]};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd32) begin
                    rad_next   = {1'b0, acc_next};
                    rem_next   = '0;
                    rt_next    = '0;
                    cnt_next   = '0;
                    state_next = SQ_ROOT;
                end
            end
            SQ_ROOT: begin
                rem_next = ge ? rem_sh - trial : rem_sh;
                rt_next  = {rt_reg[32:0], ge};
                rad_next = {rad_reg[65:0], 2'b00};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd33) begin
                    done_next  = 1'b1;
                    state_next = SQ_IDLE;
                end
            end
            default: state_next = SQ_IDLE;
        endcase
    end

    assign done = done_reg;
    assign root = rt_reg;

endmodule

/* hw/rtl/aldp_checker.sv */
// Port-level checks of the path densifier, bound to the top level.
// Depends only on the ports of arc_line_path_densifier_unit.
module aldp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [119:0] m_tdata,
    input logic [1:0]   m_tuser,
    input logic         m_tlast
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("outputs not idle after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("path end result not last of its request");

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

endmodule

bind arc_line_path_densifier_unit aldp_checker u_aldp_checker (.*);

/* dv/tb_arc_line_path_densifier_unit.sv */
// Self-checking testbench of arc_line_path_densifier_unit: line and arc requests in,
// checked polyline points out, with random gaps, stalls and register settings.
// Depends on aldp_pkg and the densifier RTL.
module tb_arc_line_path_densifier_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import aldp_pkg::*;

    localparam int      MAXPTS   = 1024;
    localparam int      MAXSTEPS = 60;
    localparam longint  DIST_SAT = 64'hFF_FFFF_FFFF;
    localparam longint  UNIT     = 65536;
    localparam longint  CYC_LIMIT = 20000000;
    localparam int      DRAIN    = 12000;
    localparam bit      KIND_LINE = 1'b0;
    localparam bit      KIND_ARC  = 1'b1;

    typedef struct {
        bit                 kind;
        logic signed [31:0] fx, fy, sx, sy;
        logic [30:0]        rad;
        logic signed [20:0] sa, ea;
        bit                 pstart, plast;
    } seg_t;

    typedef struct {
        logic signed [31:0] x, y;
        bit                 smooth;
        logic [39:0]        len_q;
        logic [9:0]         idx;
        bit                 rlast, pend;
    } point_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic s_tlast = 0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [OUT_W-1:0] m_tdata;
    logic [1:0] m_tuser;
    logic m_tlast;
    logic cfg_wr_en = 0;
    logic cfg_addr = CFG_STEP;
    logic [16:0] cfg_wdata = '0;

    arc_line_path_densifier_unit u_dut (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    // densifier model state
    longint held_x, held_y, held_dist;
    bit     held_sm, held_ok;
    int     kept_cnt;
    longint step_q = longint'(STEP_RESET);
    longint dup_lim = longint'(DUP_RESET);
    point_t seg_pts[$];
    point_t expected_pts[$];
    seg_t   pending_segs[$];
    int     errors = 0;
    longint cycles = 0;

    longint atan_q24_tab[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
        262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64,
        32, 16, 8, 4, 2};

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint exact_len(longint ux, longint uy);
        logic [69:0] sq, c, r;
        sq = 70'(ux) * 70'(ux) + 70'(uy) * 70'(uy);
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            c = r | (70'd1 << b);
            if (c * c <= sq) r = c;
        end
        return longint'(r);
    endfunction

    function automatic void sin_cos(input longint ang, output longint c, output longint s);
        longint x, y, z, xs, ys;
        bit neg;
        x = 652032874;
        y = 0;
        neg = 0;
        while (ang > 205887) ang -= 411775;
        while (ang < -205887) ang += 411775;
        if (ang > 102944) begin
            ang -= 205887;
            neg = 1;
        end else if (ang < -102944) begin
            ang += 205887;
            neg = 1;
        end
        z = ang * 256;
        for (int i = 0; i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= atan_q24_tab[i];
            end else begin
                x += ys; y -= xs; z += atan_q24_tab[i];
            end
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endfunction

    function automatic void emit_point(longint x, longint y, bit sm, longint d, int idx,
                                       bit pend);
        point_t p;
        p.x = x[31:0];
        p.y = y[31:0];
        p.smooth = sm;
        p.len_q = d[39:0];
        p.idx = idx[9:0];
        p.rlast = 0;
        p.pend = pend;
        seg_pts.push_back(p);
    endfunction

    function automatic void clear_path();
        held_x = 0; held_y = 0; held_sm = 0; held_ok = 0; held_dist = 0; kept_cnt = 0;
    endfunction

    function automatic void keep_point(longint x, longint y, bit sm);
        longint ux, uy, nd;
        nd = 0;
        if (kept_cnt >= MAXPTS) return;
        if (held_ok) begin
            ux = x - held_x;
            uy = y - held_y;
            if (ux < 0) ux = -ux;
            if (uy < 0) uy = -uy;
            if (ux < UNIT && uy < UNIT && ux * ux + uy * uy < dup_lim) begin
                if (sm) held_sm = 1;
                return;
            end
            nd = held_dist + exact_len(ux, uy);
            if (nd > DIST_SAT) nd = DIST_SAT;
            emit_point(held_x, held_y, held_sm, held_dist, kept_cnt - 1, 0);
        end
        held_x = x; held_y = y; held_sm = sm; held_dist = nd; held_ok = 1;
        kept_cnt++;
    endfunction

    function automatic void densify(seg_t sg);
        longint sweep, mag, st, ang, c, s, ox, oy, sa, ea, rad, cx, cy;
        seg_pts.delete();
        if (sg.pstart) clear_path();
        if (sg.kind == KIND_LINE) begin
            keep_point(sg.fx, sg.fy, 0);
            keep_point(sg.sx, sg.sy, 0);
        end else begin
            sa = sg.sa;
            ea = sg.ea;
            rad = sg.rad;
            cx = sg.fx;
            cy = sg.fy;
            sweep = ea - sa;
            mag = sweep < 0 ? -sweep : sweep;
            st = mag / (step_q == 0 ? 1 : step_q) + 1;
            if (st > MAXSTEPS) st = MAXSTEPS;
            if (st < 2) st = 2;
            for (longint j = 0; j <= st; j++) begin
                ang = sa + (sweep * j) / st;
                sin_cos(ang, c, s);
                ox = (rad * c + (64'sd1 << 29)) >>> 30;
                oy = (rad * s + (64'sd1 << 29)) >>> 30;
                keep_point(sat32(cx + ox), sat32(cy + oy), j > 0 && j < st);
            end
        end
        if (sg.plast) begin
            if (held_ok) emit_point(held_x, held_y, held_sm, held_dist, kept_cnt - 1, 1);
            clear_path();
        end
        if (seg_pts.size() > 0) seg_pts[seg_pts.size() - 1].rlast = 1;
        foreach (seg_pts[i]) expected_pts.push_back(seg_pts[i]);
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("point mismatch on %s: got %0h, expected %0h", field, got, want);
        errors++;
    endtask

    // request driver
    seg_t cur_seg;
    bit   in_fire = 0, in_busy = 0, quiet = 0;
    int   in_gap = 0;

    always @(posedge aclk) begin
        in_fire = aresetn && s_tvalid && s_tready;
        if (in_fire) densify(cur_seg);
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_fire) begin
                in_busy = 0;
                in_fire = 0;
                in_gap = quiet ? 0 : $urandom_range(0, 8);
            end
            if (!in_busy) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pending_segs.size() > 0) begin
                    cur_seg = pending_segs.pop_front();
                    in_busy = 1;
                    if ($urandom_range(0, 29) == 0) quiet = !quiet;
                end
            end
            s_tvalid <= in_busy;
            s_tdata <= {7'd0, cur_seg.ea, cur_seg.sa, cur_seg.rad, cur_seg.sy, cur_seg.sx,
                        cur_seg.fy, cur_seg.fx};
            s_tuser <= {cur_seg.pstart, cur_seg.kind};
            s_tlast <= cur_seg.plast;
        end
    end

    // result monitor and stall
    bit out_fire = 0;
    int out_stall = 0;
    point_t want;

    always @(posedge aclk) begin
        cycles++;
        out_fire = aresetn && m_tvalid && m_tready;
        if (out_fire) begin
            if (expected_pts.size() == 0) begin
                report("unexpected point_x", m_tdata[31:0], 0);
            end else begin
                want = expected_pts.pop_front();
                if (m_tdata[31:0] !== want.x) report("point_x", m_tdata[31:0], want.x);
                if (m_tdata[63:32] !== want.y) report("point_y", m_tdata[63:32], want.y);
                if (m_tdata[103:64] !== want.len_q)
                    report("distance", m_tdata[103:64], want.len_q);
                if (m_tdata[113:104] !== want.idx)
                    report("point_index", m_tdata[113:104], want.idx);
                if (m_tuser[0] !== want.smooth) report("smooth", m_tuser[0], want.smooth);
                if (m_tuser[1] !== want.pend) report("path_end", m_tuser[1], want.pend);
                if (m_tlast !== want.rlast) report("run_last", m_tlast, want.rlast);
            end
        end
        if (cycles > CYC_LIMIT) begin
            $display("tb_arc_line_path_densifier_unit: FAIL");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (out_fire) begin
                out_fire = 0;
                out_stall = quiet ? 0 : $urandom_range(0, 8);
            end
            if (out_stall > 0) begin
                out_stall--;
                m_tready <= 0;
            end else begin
                m_tready <= 1;
            end
        end
    end

    // stimulus
    task automatic add_line(longint fx, longint fy, longint sx, longint sy, bit ps, bit pl);
        seg_t sg;
        sg.kind = KIND_LINE;
        sg.fx = fx[31:0]; sg.fy = fy[31:0]; sg.sx = sx[31:0]; sg.sy = sy[31:0];
        sg.rad = 31'($urandom);
        sg.sa = 21'($urandom);
        sg.ea = 21'($urandom);
        sg.pstart = ps; sg.plast = pl;
        pending_segs.push_back(sg);
    endtask

    task automatic add_arc(longint cx, longint cy, longint r, longint sa, longint ea,
                           bit ps, bit pl);
        seg_t sg;
        sg.kind = KIND_ARC;
        sg.fx = cx[31:0]; sg.fy = cy[31:0];
        sg.sx = $urandom; sg.sy = $urandom;
        sg.rad = r[30:0]; sg.sa = sa[20:0]; sg.ea = ea[20:0];
        sg.pstart = ps; sg.plast = pl;
        pending_segs.push_back(sg);
    endtask

    task automatic write_reg(logic idx, longint v);
        @(negedge aclk);
        cfg_wr_en <= 1;
        cfg_addr <= idx;
        cfg_wdata <= v[16:0];
        if (idx == CFG_STEP) step_q = longint'(v[16:0]);
        else dup_lim = longint'(v[15:0]);
        @(negedge aclk);
        cfg_wr_en <= 0;
    endtask

    task automatic drain();
        while (pending_segs.size() > 0 || in_busy || expected_pts.size() > 0)
            @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    function automatic longint near_coord(longint base);
        case ($urandom_range(0, 9))
            0: return longint'(int'($urandom));
            1: return $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
            2, 3: return sat32(base + $urandom_range(0, 6) - 3);
            default: return sat32(base + longint'($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    task automatic random_paths(int nseg);
        longint px, py, sa, ea, r, nx, ny;
        bit ps, pl;
        px = 0; py = 0;
        ps = 1;
        for (int i = 0; i < nseg; i++) begin
            pl = (i == nseg - 1) || ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 15) == 0) ps = 1;
            if ($urandom_range(0, 1)) begin
                nx = near_coord(px);
                ny = near_coord(py);
                add_line(near_coord(px), near_coord(py), nx, ny, ps, pl);
                px = nx; py = ny;
            end else begin
                case ($urandom_range(0, 7))
                    0: r = $urandom & 32'h7FFF_FFFF;
                    1: r = $urandom_range(0, 3);
                    default: r = $urandom_range(0, 1 << 20);
                endcase
                sa = longint'($urandom_range(0, 1647100)) - 823550;
                if ($urandom_range(0, 9) == 0) ea = longint'($urandom_range(0, 1647100)) - 823550;
                else ea = sa + longint'($urandom_range(0, 40000)) - 20000;
                if (ea > 823550) ea = 823550;
                if (ea < -823550) ea = -823550;
                add_arc(near_coord(px), near_coord(py), r, sa, ea, ps, pl);
            end
            ps = pl ? ($urandom_range(0, 3) != 0) : 0;
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: defaults
        add_line(0, 0, 10 * UNIT, 0, 1, 0);
        add_line(10 * UNIT, 0, 10 * UNIT + 3, 2, 0, 0);
        add_arc(0, 0, 5 * UNIT, 0, 205887, 0, 0);
        add_arc(UNIT, UNIT, UNIT, 100, 100, 0, 0);
        add_arc(0, 0, 64'h7FFF_FFFF, 823550, -823550, 0, 1);
        add_arc(3 * UNIT, 3 * UNIT, 0, -1000, 50000, 1, 0);
        add_line(3 * UNIT, 3 * UNIT, 4 * UNIT, 3 * UNIT, 0, 1);
        add_line(0, 0, UNIT, UNIT, 1, 0);
        add_line(2 * UNIT, 0, 5 * UNIT, UNIT, 1, 1);
        add_line(-64'sd2147483648, -64'sd2147483648, 64'sd2147483647, 64'sd2147483647, 1, 1);
        add_arc(64'sd2147483647, -64'sd2147483648, 64'h7FFF_FFFF, -411775, 411775, 1, 1);
        add_line(7, 7, 7, 7, 0, 1);
        add_arc(0, 0, 2 * UNIT, -823550, -823550, 0, 1);
        drain();

        random_paths(40);
        drain();

        write_reg(CFG_STEP, 65536);
        write_reg(CFG_DUP, 65535);
        random_paths(25);
        drain();

        // capacity: long arcs fill the polyline
        write_reg(CFG_STEP, 1);
        write_reg(CFG_DUP, 0);
        for (int i = 0; i < 18; i++)
            add_arc(0, 0, (i + 1) * UNIT, -205887, 205887, i == 0, i == 17);
        random_paths(20);
        drain();

        // length saturation over corner-to-corner lines
        write_reg(CFG_STEP, $urandom_range(1, 65536));
        write_reg(CFG_DUP, $urandom_range(0, 65535));
        for (int i = 0; i < 95; i++)
            add_line(-64'sd2147483648, -64'sd2147483648, 64'sd2147483647, 64'sd2147483647,
                     i == 0, i == 94);
        random_paths(30);
        drain();

        if (errors == 0) begin
            $display("tb_arc_line_path_densifier_unit: PASS");
        end else begin
            $display("tb_arc_line_path_densifier_unit: FAIL");
        end
        $finish;
    end
endmodule
